// ===== rtl/core/lzss_text_token_encoder_unit_macros.svh =====
// assertion macros used by the checker file
`ifndef LZSS_TEXT_TOKEN_ENCODER_UNIT_MACROS_SVH
`define LZSS_TEXT_TOKEN_ENCODER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LTTE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ltte assertion failed");

// next-cycle implication, disabled while in reset
`define LTTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ltte assertion failed");

`endif

// ===== rtl/core/ltte_pkg.sv =====
// shared constants, types and helper functions of the lzss token encoder
package ltte_pkg;

    localparam int HistDepth = 1024;
    localparam int LaDepth   = 16;
    localparam int HistAw    = $clog2(HistDepth);
    localparam int SeenW     = HistAw + 1;
    localparam int LaAw      = $clog2(LaDepth);
    localparam int FillW     = LaAw + 1;
    localparam int WinW      = 11;
    localparam int TokMax    = 9;
    localparam int TokCw     = $clog2(TokMax + 1);
    localparam int QDepth    = 4;
    localparam int QAw       = $clog2(QDepth);

    localparam logic [WinW-1:0] WinReset = WinW'(1024);

    localparam logic [7:0] ChLt    = 8'h3C;
    localparam logic [7:0] ChGt    = 8'h3E;
    localparam logic [7:0] ChComma = 8'h2C;
    localparam logic [7:0] ChZero  = 8'h30;

    typedef enum logic [1:0] {K_FILL, K_ENCODE, K_FLUSH} t_kind;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
    } t_qitem;

    typedef enum logic [2:0] {
        S_IDLE, S_HEAD, S_RD, S_CMP, S_EMIT, S_COMMIT, S_DONE
    } t_state;

    typedef logic [3:0][3:0] t_bcd;

    typedef struct packed {
        logic [TokMax-1:0][7:0] ch;
        logic [TokCw-1:0]       n;
    } t_token;

    // decimal increment over four digits
    function automatic t_bcd bcd_inc(t_bcd v);
        t_bcd r;
        logic cy;
        r  = v;
        cy = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (cy) begin
                if (r[i] == 4'd9) begin
                    r[i] = 4'd0;
                end else begin
                    r[i] = r[i] + 4'd1;
                    cy   = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // count of significant decimal digits
    function automatic logic [2:0] bcd_digits(t_bcd v);
        logic [2:0] n;
        if (v[3] != 4'd0)      n = 3'd4;
        else if (v[2] != 4'd0) n = 3'd3;
        else if (v[1] != 4'd0) n = 3'd2;
        else                   n = 3'd1;
        return n;
    endfunction

    // tens digit of a short length, by reciprocal multiply
    function automatic logic [3:0] len_tens(logic [FillW-1:0] len);
        logic [15:0] p;
        p = 16'(len) * 16'd13;
        return 4'(p >> 7);
    endfunction

    // single literal item
    function automatic t_token lit_token(logic [7:0] b);
        t_token t;
        t       = '0;
        t.ch[0] = b;
        t.n     = TokCw'(1);
        return t;
    endfunction

    // ascii token <d,len>
    function automatic t_token build_token(t_bcd d, logic [FillW-1:0] len);
        t_token           t;
        logic [TokCw-1:0] p;
        logic [2:0]       nd;
        logic [3:0]       tens;
        logic [7:0]       ones;
        t    = '0;
        p    = '0;
        nd   = bcd_digits(d);
        tens = len_tens(len);
        ones = 8'(len) - 8'(tens) * 8'd10;
        t.ch[p] = ChLt;
        p = p + 1'b1;
        for (int i = 3; i >= 0; i--) begin
            if (3'(i) < nd) begin
                t.ch[p] = ChZero + {4'h0, d[i]};
                p = p + 1'b1;
            end
        end
        t.ch[p] = ChComma;
        p = p + 1'b1;
        if (tens != 4'd0) begin
            t.ch[p] = ChZero + {4'h0, tens};
            p = p + 1'b1;
        end
        t.ch[p] = ChZero + ones;
        p = p + 1'b1;
        t.ch[p] = ChGt;
        p = p + 1'b1;
        t.n = p;
        return t;
    endfunction

endpackage

// ===== rtl/core/ltte_front.sv =====
// front part: accepts bytes, tags each with its encode kind, queues them
module ltte_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [7:0]          i_s_tdata,
    input  logic                i_s_tlast,
    output logic                o_q_vld,
    output ltte_pkg::t_qitem    o_q_item,
    input  logic                i_q_pop
);
    import ltte_pkg::*;

    t_qitem            r_q [QDepth];
    logic [QAw-1:0]    r_wp, n_wp, r_rp, n_rp;
    logic [QAw:0]      r_cnt, n_cnt;
    logic [LaAw-1:0]   r_fill, n_fill;
    logic              push, pop;
    t_qitem            item;

    assign o_s_tready = (r_cnt != (QAw+1)'(QDepth));
    assign push       = i_s_tvalid && o_s_tready;
    assign o_q_vld    = (r_cnt != '0);
    assign pop        = i_q_pop && o_q_vld;
    assign o_q_item   = r_q[r_rp];

    // classify by the lookahead level the item meets
    always_comb begin
        item.data = i_s_tdata;
        n_fill    = r_fill;
        if (i_s_tlast) begin
            item.kind = K_FLUSH;
            n_fill    = '0;
        end else if (r_fill == LaAw'(LaDepth - 1)) begin
            item.kind = K_ENCODE;
        end else begin
            item.kind = K_FILL;
            n_fill    = r_fill + 1'b1;
        end
        n_wp  = push ? r_wp + 1'b1 : r_wp;
        n_rp  = pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (QAw+1)'(push) - (QAw+1)'(pop);
    end

    // queue pointers and lookahead level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_fill <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
            if (push) begin
                r_fill <= n_fill;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

endmodule

// ===== rtl/core/ltte_back.sv =====
// back part: lookahead, history, match search and token output
module ltte_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ltte_pkg::WinW-1:0]  i_window,
    input  logic                       i_q_vld,
    input  ltte_pkg::t_qitem           i_q_item,
    output logic                       o_q_pop,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [7:0]                 o_m_tdata,
    output logic                       o_m_tlast,
    output logic                       o_m_tuser
);
    import ltte_pkg::*;

    t_state            r_state, n_state;
    logic [7:0]        r_la [LaDepth];
    logic [7:0]        n_la [LaDepth];
    logic [FillW-1:0]  r_fill, n_fill;
    logic [SeenW-1:0]  r_seen, n_seen;
    logic [FillW-1:0]  r_skip, n_skip;
    logic [HistAw-1:0] r_wr, n_wr;
    logic              r_flush, n_flush;
    logic [SeenW-1:0]  r_d, n_d, r_w, n_w;
    t_bcd              r_dbcd, n_dbcd, r_bbcd, n_bbcd;
    logic [FillW-1:0]  r_len, n_len, r_cap, n_cap, r_blen, n_blen;
    t_token            r_tok, n_tok;
    logic [TokCw-1:0]  r_k, n_k;
    logic              r_pend_vld, n_pend_vld;
    logic [7:0]        r_pend_ch, n_pend_ch;
    logic              r_out_vld, n_out_vld;
    logic [7:0]        r_out_ch, n_out_ch;
    logic              r_out_last, n_out_last, r_out_end, n_out_end;

    logic [7:0]        r_hist [HistDepth];
    logic [7:0]        r_rd_data;
    logic [HistAw-1:0] rd_addr;
    logic              mem_we;

    logic              out_free;
    logic [SeenW-1:0]  win_c, w;
    logic              eq, qual;
    logic [FillW-1:0]  mlen, nb;
    t_bcd              nbb;
    logic [7:0]        thr;
    logic [SeenW-1:0]  d1;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_ch;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_end;
    assign out_free   = !r_out_vld || i_m_tready;
    assign rd_addr    = r_wr - r_d[HistAw-1:0] + HistAw'(r_len);

    // history memory: write on commit, registered read for the search
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist[r_wr] <= r_la[0];
        end
        r_rd_data <= r_hist[rd_addr];
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_la       = r_la;
        n_fill     = r_fill;
        n_seen     = r_seen;
        n_skip     = r_skip;
        n_wr       = r_wr;
        n_flush    = r_flush;
        n_d        = r_d;
        n_w        = r_w;
        n_dbcd     = r_dbcd;
        n_bbcd     = r_bbcd;
        n_len      = r_len;
        n_cap      = r_cap;
        n_blen     = r_blen;
        n_tok      = r_tok;
        n_k        = r_k;
        n_pend_vld = r_pend_vld;
        n_pend_ch  = r_pend_ch;
        n_out_vld  = r_out_vld && !i_m_tready;
        n_out_ch   = r_out_ch;
        n_out_last = r_out_last;
        n_out_end  = r_out_end;
        o_q_pop    = 1'b0;
        mem_we     = 1'b0;

        win_c = (32'(i_window) > HistDepth) ? SeenW'(HistDepth) : SeenW'(i_window);
        w     = (win_c < r_seen) ? win_c : r_seen;
        eq    = (r_rd_data == r_la[r_len[LaAw-1:0]]);
        mlen  = eq ? r_len + 1'b1 : r_len;
        thr   = 8'(bcd_digits(r_dbcd)) + ((mlen >= FillW'(10)) ? 8'd2 : 8'd1) + 8'd4;
        qual  = (8'(mlen) > thr) && (mlen >= r_blen);
        nb    = qual ? mlen : r_blen;
        nbb   = qual ? r_dbcd : r_bbcd;
        d1    = r_d + 1'b1;

        unique case (r_state)
            // take the next queued item into the lookahead
            S_IDLE: begin
                o_q_pop = i_q_vld;
                if (i_q_vld) begin
                    for (int i = 0; i < LaDepth; i++) begin
                        if (LaAw'(i) == r_fill[LaAw-1:0]) begin
                            n_la[i] = i_q_item.data;
                        end
                    end
                    n_fill  = r_fill + 1'b1;
                    n_flush = (i_q_item.kind == K_FLUSH);
                    if (i_q_item.kind != K_FILL) begin
                        n_state = S_HEAD;
                    end
                end
            end
            // decide skip, literal or search for the head byte
            S_HEAD: begin
                if (r_skip != '0) begin
                    n_skip  = r_skip - 1'b1;
                    n_state = S_COMMIT;
                end else if (w == '0) begin
                    n_tok   = lit_token(r_la[0]);
                    n_k     = '0;
                    n_state = S_EMIT;
                end else begin
                    n_w     = w;
                    n_d     = SeenW'(1);
                    n_dbcd  = t_bcd'(16'h0001);
                    n_len   = '0;
                    n_cap   = FillW'(1);
                    n_blen  = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            // compare one byte, then extend, move to the next distance or finish with a token or literal
            S_CMP: begin
                if (eq && (mlen < r_cap)) begin
                    n_len   = mlen;
                    n_state = S_RD;
                end else begin
                    n_blen = nb;
                    n_bbcd = nbb;
                    if (r_d == r_w) begin
                        if (nb != '0) begin
                            n_tok  = build_token(nbb, nb);
                            n_skip = nb - 1'b1;
                        end else begin
                            n_tok  = lit_token(r_la[0]);
                        end
                        n_k     = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_d     = d1;
                        n_dbcd  = bcd_inc(r_dbcd);
                        n_len   = '0;
                        n_cap   = (d1 > r_fill) ? r_fill : FillW'(d1);
                        n_state = S_RD;
                    end
                end
            end
            // move token items through the pending stage
            S_EMIT: begin
                if (!r_pend_vld || out_free) begin
                    if (r_pend_vld) begin
                        n_out_vld  = 1'b1;
                        n_out_ch   = r_pend_ch;
                        n_out_last = 1'b0;
                        n_out_end  = 1'b0;
                    end
                    n_pend_vld = 1'b1;
                    n_pend_ch  = r_tok.ch[r_k];
                    n_k        = r_k + 1'b1;
                    if (r_k == r_tok.n - 1'b1) begin
                        n_state = S_COMMIT;
                    end
                end
            end
            // move the head into history
            S_COMMIT: begin
                mem_we = 1'b1;
                n_wr   = r_wr + 1'b1;
                if (r_seen < SeenW'(HistDepth)) begin
                    n_seen = r_seen + 1'b1;
                end
                for (int i = 0; i < LaDepth - 1; i++) begin
                    n_la[i] = r_la[i+1];
                end
                n_fill = r_fill - 1'b1;
                if (r_flush && (r_fill != FillW'(1))) begin
                    n_state = S_HEAD;
                end else begin
                    if (r_flush) begin
                        n_fill = '0;
                        n_seen = '0;
                        n_skip = '0;
                        n_wr   = '0;
                    end
                    n_state = S_DONE;
                end
            end
            // release the final item of this input with its flags
            S_DONE: begin
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_ch   = r_pend_ch;
                    n_out_last = 1'b1;
                    n_out_end  = r_flush;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_seen     <= '0;
            r_skip     <= '0;
            r_wr       <= '0;
            r_flush    <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_seen     <= n_seen;
            r_skip     <= n_skip;
            r_wr       <= n_wr;
            r_flush    <= n_flush;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // payload and search registers
    always_ff @(posedge i_clk) begin
        r_la       <= n_la;
        r_d        <= n_d;
        r_w        <= n_w;
        r_dbcd     <= n_dbcd;
        r_bbcd     <= n_bbcd;
        r_len      <= n_len;
        r_cap      <= n_cap;
        r_blen     <= n_blen;
        r_tok      <= n_tok;
        r_k        <= n_k;
        r_pend_ch  <= n_pend_ch;
        r_out_ch   <= n_out_ch;
        r_out_last <= n_out_last;
        r_out_end  <= n_out_end;
    end

endmodule

// ===== rtl/core/lzss_text_token_encoder_unit.sv =====
// top level of the lzss text token encoder
//
// Input stream: one raw byte per item in tdata, tlast marks the last byte of a block.
// Output stream: one encoded byte per item in tdata (literal or token character),
// tlast marks the final item caused by one input item, tuser marks the block's
// final encoded byte.
// Config channel: i_cfg_data sets the search window (1..1024 earlier bytes), taken
// whenever i_cfg_valid is high; write it only while the block is idle.
// Bytes first fill a 16-byte lookahead; a byte that finds it full encodes the
// head, and the last byte of a block encodes every byte still queued.
// Each encoded position that no earlier match covers walks every distance of the
// window through one history read port, with a read state and a compare state per
// compared byte, and then emits its output characters.
// A four-item input queue decouples the input side from the search engine.
// Reset empties the queue, lookahead and output register and sets the window to 1024.
// When the receiver stalls, the output register and one pending character hold
// and the engine waits; input is still taken until the queue fills.
module lzss_text_token_encoder_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [7:0]                 i_s_axis_tdata,   // data_byte
    input  logic                       i_s_axis_tlast,   // last_byte
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [7:0]                 o_m_axis_tdata,   // out_char
    output logic                       o_m_axis_tlast,   // run_last
    output logic                       o_m_axis_tuser,   // block_end
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [ltte_pkg::WinW-1:0]  i_cfg_data
);
    import ltte_pkg::*;

    logic [WinW-1:0] r_window;
    logic            q_vld, q_pop;
    t_qitem          q_item;

    assign o_cfg_ready = 1'b1;

    // window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WinReset;
        end else if (i_cfg_valid) begin
            r_window <= i_cfg_data;
        end
    end

    ltte_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tlast  (i_s_axis_tlast),
        .o_q_vld    (q_vld),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    ltte_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_window   (r_window),
        .i_q_vld    (q_vld),
        .i_q_item   (q_item),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast),
        .o_m_tuser  (o_m_axis_tuser)
    );

endmodule

// ===== rtl/core/ltte_checker.sv =====
// port-level checks of the encoder and their binding
`include "lzss_text_token_encoder_unit_macros.svh"

module ltte_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_m_axis_tvalid,
    input logic                       i_m_axis_tready,
    input logic [7:0]                 o_m_axis_tdata,
    input logic                       o_m_axis_tlast,
    input logic                       o_m_axis_tuser
);

    // a stalled output item holds
    `LTTE_ASSERT_NEXT(a_out_hold,
        o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable({o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser}))

    // block end is always the last item of its input
    `LTTE_ASSERT_NOW(a_end_is_last, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tlast)

    // nothing leaves right after reset
    `LTTE_ASSERT_NOW(a_quiet_after_reset, $rose(i_rst_n), !o_m_axis_tvalid)

endmodule

bind lzss_text_token_encoder_unit ltte_checker u_ltte_checker (.*);
